// ----- src/sipba_pkg.sv -----
package sipba_pkg;

	// Default table depth and fixed frame-size constants.
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int SHORT_LIMIT = 60;
	localparam int MIN_WIRE = 64;
	localparam int FCS_BYTES = 4;
	localparam logic [15:0] IPV4_ETHERTYPE_RST = 16'h0800;

	// Field widths of the result item.
	localparam int INDEX_BITS = 6;
	localparam int COUNT_BITS = 7;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_NOT_IPV4 = 2'd0,
		STATUS_UPDATED  = 2'd1,
		STATUS_NEW      = 2'd2,
		STATUS_FULL     = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SUM,
		ST_FIN
	} state_t;

	// One captured frame.
	typedef struct packed {
		logic [15:0] ethertype;
		logic [31:0] src_address;
		logic [15:0] frame_length;
	} frame_item_t;

	// One accounting result.
	typedef struct packed {
		logic [1:0]            status;
		logic [INDEX_BITS-1:0] entry_index;
		logic [31:0]           entry_bytes;
		logic [COUNT_BITS-1:0] entry_count;
		logic [31:0]           top_address;
		logic [31:0]           top_bytes;
	} result_item_t;

endpackage

// ----- src/sipba_ram.sv -----
module sipba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/sipba_engine.sv -----
module sipba_engine
	import sipba_pkg::*;
#(
	parameter int DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [15:0]              cfg_ethertype,
	input  logic                     frame_valid,
	output logic                     frame_ready,
	input  frame_item_t              frame,
	output logic                     result_valid,
	input  logic                     result_ready,
	output result_item_t             result,
	output logic                     rd_en,
	output logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [31:0]              addr_rdata,
	input  logic [31:0]              bytes_rdata,
	output logic                     addr_we,
	output logic                     bytes_we,
	output logic [$clog2(DEPTH)-1:0] wr_addr,
	output logic [31:0]              addr_wdata,
	output logic [31:0]              bytes_wdata
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [31:0]   addr_q;
	logic [16:0]   wire_q;
	logic [CW-1:0] idx_q;
	logic          issued_s1;
	logic [IW-1:0] idx_s1;
	logic [31:0]   old_bytes_q;
	logic          hit_q;
	status_t       status_q;
	logic [IW-1:0] ent_idx_q;
	logic [31:0]   total_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] top_idx_q;
	logic [31:0]   top_total_q;
	logic [31:0]   top_addr_q;
	logic          out_valid_q;
	result_item_t  out_item_q;

	logic          accept;
	logic          is_ipv4;
	logic [16:0]   wire_d;
	logic          match;
	logic          miss;
	logic          out_free;
	logic          fin;
	logic          accounted;
	logic          beats_top;
	logic [CW-1:0] count_d;
	logic [IW-1:0] top_idx_d;
	logic [31:0]   top_total_d;
	logic [31:0]   top_addr_d;
	logic [32:0]   sum;
	logic [IW+INDEX_BITS-1:0] idx_ext;
	logic [CW+COUNT_BITS-1:0] count_ext;

	// Input classification and wire size.
	assign accept  = frame_valid && frame_ready;
	assign is_ipv4 = frame.ethertype == cfg_ethertype;
	assign wire_d  = (frame.frame_length >= 16'(SHORT_LIMIT))
		? {1'b0, frame.frame_length} + 17'(FCS_BYTES) : 17'(MIN_WIRE);

	// Search over the address memory: issue one read a cycle, compare each entry in the cycle after its read.
	assign rd_en   = (state_q == ST_SEARCH) && (idx_q < count_q);
	assign rd_addr = idx_q[IW-1:0];
	assign match   = (state_q == ST_SEARCH) && issued_s1 && (addr_rdata == addr_q);
	assign miss    = (state_q == ST_SEARCH) && !issued_s1 && !rd_en;

	// Saturating add for an existing entry.
	assign sum = {1'b0, old_bytes_q} + {16'b0, wire_q};

	// Final update: top sender, count and write-back.
	assign out_free  = !out_valid_q || result_ready;
	assign fin       = (state_q == ST_FIN) && out_free;
	assign accounted = (status_q == STATUS_UPDATED) || (status_q == STATUS_NEW);
	assign beats_top = (total_q > top_total_q)
		|| ((total_q == top_total_q) && (ent_idx_q <= top_idx_q));

	always_comb begin
		count_d     = count_q;
		top_idx_d   = top_idx_q;
		top_total_d = top_total_q;
		top_addr_d  = top_addr_q;
		if (status_q == STATUS_NEW) begin
			count_d = count_q + CW'(1);
		end
		if (accounted && beats_top) begin
			top_idx_d   = ent_idx_q;
			top_total_d = total_q;
			top_addr_d  = addr_q;
		end
	end

	assign addr_we     = fin && (status_q == STATUS_NEW);
	assign bytes_we    = fin && accounted;
	assign wr_addr     = ent_idx_q;
	assign addr_wdata  = addr_q;
	assign bytes_wdata = total_q;

	assign idx_ext   = {{INDEX_BITS{1'b0}}, ent_idx_q};
	assign count_ext = {{COUNT_BITS{1'b0}}, count_d};

	// Next state and handshake.
	always_comb begin
		state_d     = state_q;
		frame_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				frame_ready = 1'b1;
				if (frame_valid) begin
					state_d = is_ipv4 ? ST_SEARCH : ST_FIN;
				end
			end
			ST_SEARCH: begin
				if (match || miss) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_s1   <= 1'b0;
			count_q     <= '0;
			top_idx_q   <= '0;
			top_total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			issued_s1 <= rd_en;
			if (fin) begin
				count_q     <= count_d;
				top_idx_q   <= top_idx_d;
				top_total_q <= top_total_d;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q   <= frame.src_address;
			wire_q   <= wire_d;
			idx_q    <= '0;
			status_q <= STATUS_NOT_IPV4;
		end
		if (rd_en) begin
			idx_q  <= idx_q + CW'(1);
			idx_s1 <= idx_q[IW-1:0];
		end
		if (state_q == ST_SEARCH) begin
			hit_q       <= match;
			old_bytes_q <= bytes_rdata;
			ent_idx_q   <= match ? idx_s1 : count_q[IW-1:0];
		end
		if (state_q == ST_SUM) begin
			if (hit_q) begin
				status_q <= STATUS_UPDATED;
				total_q  <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
			end else begin
				status_q <= (count_q < CW'(DEPTH)) ? STATUS_NEW : STATUS_FULL;
				total_q  <= {15'b0, wire_q};
			end
		end
		if (fin) begin
			top_addr_q              <= top_addr_d;
			out_item_q.status       <= status_q;
			out_item_q.entry_index  <= accounted ? idx_ext[INDEX_BITS-1:0] : '0;
			out_item_q.entry_bytes  <= accounted ? total_q : '0;
			out_item_q.entry_count  <= count_ext[COUNT_BITS-1:0];
			out_item_q.top_address  <= (count_d != '0) ? top_addr_d : '0;
			out_item_q.top_bytes    <= (count_d != '0) ? top_total_d : '0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_item_q;

`ifndef SYNTHESIS
	// The table never holds more entries than it has rows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	// The top total never falls.
	a_top_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> top_total_q >= $past(top_total_q))
		else $error("top total decreased");

	// The count only ever grows by one.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> count_q == $past(count_q) + CW'(1))
		else $error("entry count jumped");

	// An empty table has no top total.
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> top_total_q == '0)
		else $error("top total set with empty table");

	// An updated entry lies inside the filled part of the table.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fin && (status_q == STATUS_UPDATED) |-> CW'(ent_idx_q) < count_q)
		else $error("updated entry outside the table");
`endif

endmodule

// ----- src/source_ip_byte_accounting.sv -----
// Channel  Signals                              Moves
// frame    frame_valid, frame_ready, frame      one captured frame item in
// result   result_valid, result_ready, result   one accounting result item out
// cfg      cfg_we, cfg_wdata                    IPv4 EtherType register write
//
// A non-IPv4 item skips the search. An IPv4 item's address search reads one entry a cycle,
// up to the entry that it hits, or over all stored entries on a miss (none on an empty table).
// One item is in work at a time; the next is taken while a result waits.
// Reset clears the count and top sender; the memories need no clearing pass.
// A stalled result holds the block in its final step until it is taken.
module source_ip_byte_accounting
	import sipba_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata,
	input  logic         frame_valid,
	output logic         frame_ready,
	input  frame_item_t  frame,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	localparam int IW = $clog2(TABLE_DEPTH);

	logic [15:0]   ethertype_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic [31:0]   addr_rdata;
	logic [31:0]   bytes_rdata;
	logic          addr_we;
	logic          bytes_we;
	logic [IW-1:0] wr_addr;
	logic [31:0]   addr_wdata;
	logic [31:0]   bytes_wdata;

	// EtherType register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ethertype_q <= IPV4_ETHERTYPE_RST;
		end else if (cfg_we) begin
			ethertype_q <= cfg_wdata;
		end
	end

	// Address and byte total memories share the read address.
	sipba_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_addr_ram (
		.clk  (clk),
		.we   (addr_we),
		.waddr(wr_addr),
		.wdata(addr_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(addr_rdata)
	);

	sipba_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_bytes_ram (
		.clk  (clk),
		.we   (bytes_we),
		.waddr(wr_addr),
		.wdata(bytes_wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(bytes_rdata)
	);

	// Search, update and result sequencer.
	sipba_engine #(
		.DEPTH(TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_ethertype(ethertype_q),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.addr_rdata   (addr_rdata),
		.bytes_rdata  (bytes_rdata),
		.addr_we      (addr_we),
		.bytes_we     (bytes_we),
		.wr_addr      (wr_addr),
		.addr_wdata   (addr_wdata),
		.bytes_wdata  (bytes_wdata)
	);

endmodule

// ----- verif/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sipba_pkg::*;

	localparam int DEPTH = TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 4000000;
	localparam logic [31:0] SATURATED = 32'hFFFF_FFFF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [15:0]  cfg_wdata = 16'h0000;
	logic         frame_valid = 1'b0;
	logic         frame_ready;
	frame_item_t  frame = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_item_t result;

	// Stimulus and prediction bookkeeping.
	frame_item_t  pending_frames[$];
	result_item_t expected_results[$];
	logic [31:0]  known_sources[$];
	int           frames_taken = 0;
	int           gap_left = 0;
	int           mismatches = 0;
	int           cycle_count = 0;
	logic         quiet_stretch;

	// Predicted state of the accounting table.
	logic [15:0]  ethertype_reg = IPV4_ETHERTYPE_RST;
	logic [31:0]  addr_tab[DEPTH];
	logic [31:0]  total_tab[DEPTH];
	int unsigned  n_stored = 0;
	int unsigned  lead_idx = 0;
	logic [31:0]  lead_total = '0;

	source_ip_byte_accounting #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame(frame),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Neither side idles for a while early in the run.
	assign quiet_stretch = (frames_taken >= 100) && (frames_taken < 260);

	// Updates the running top sender; equal totals go to the lower index.
	function automatic void note_lead(input int unsigned idx, input logic [31:0] total);
		if (total > lead_total || (total == lead_total && idx <= lead_idx)) begin
			lead_idx = idx;
			lead_total = total;
		end
	endfunction

	// Accounts one accepted frame in the predicted table and returns its result.
	function automatic result_item_t account_frame(input frame_item_t f);
		result_item_t r;
		logic [31:0]  wire_len;
		logic [32:0]  sum;
		int unsigned  i;
		logic         found;
		r = '0;
		r.status = STATUS_NOT_IPV4;
		if (f.ethertype == ethertype_reg) begin
			wire_len = (f.frame_length >= SHORT_LIMIT) ?
				32'(f.frame_length) + FCS_BYTES : MIN_WIRE;
			found = 1'b0;
			i = 0;
			while (i < n_stored && !found) begin
				if (addr_tab[i] == f.src_address) begin
					found = 1'b1;
				end else begin
					i++;
				end
			end
			if (found) begin
				sum = {1'b0, total_tab[i]} + {1'b0, wire_len};
				total_tab[i] = sum[32] ? SATURATED : sum[31:0];
				r.status = STATUS_UPDATED;
				r.entry_index = i[INDEX_BITS-1:0];
				r.entry_bytes = total_tab[i];
				note_lead(i, total_tab[i]);
			end else if (n_stored < DEPTH) begin
				i = n_stored;
				addr_tab[i] = f.src_address;
				total_tab[i] = wire_len;
				n_stored++;
				r.status = STATUS_NEW;
				r.entry_index = i[INDEX_BITS-1:0];
				r.entry_bytes = wire_len;
				note_lead(i, wire_len);
			end else begin
				r.status = STATUS_FULL;
			end
		end
		r.entry_count = n_stored[COUNT_BITS-1:0];
		if (n_stored > 0) begin
			r.top_address = addr_tab[lead_idx];
			r.top_bytes = lead_total;
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// Frame driver: presents queued items, with random hold-offs between them.
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
		end else if (!frame_valid || frame_ready) begin
			if (gap_left != 0) begin
				gap_left--;
				frame_valid <= 1'b0;
			end else if (pending_frames.size() != 0 && !quiet_stretch &&
				$urandom_range(0, 99) < 3) begin
				gap_left = $urandom_range(0, 4);
				frame_valid <= 1'b0;
			end else if (pending_frames.size() != 0) begin
				frame <= pending_frames.pop_front();
				frame_valid <= 1'b1;
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	// Result receiver stalls at random.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			result_ready <= quiet_stretch || ($urandom_range(0, 99) >= 7);
		end
	end

	// Monitor: tracks register writes, checks results and predicts accepted items.
	always @(posedge clk) begin
		result_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				ethertype_reg = cfg_wdata;
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("result item arrived with no prediction waiting");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", 32'(want.status), 32'(result.status));
					check_field("entry_index", 32'(want.entry_index),
						32'(result.entry_index));
					check_field("entry_bytes", want.entry_bytes, result.entry_bytes);
					check_field("entry_count", 32'(want.entry_count),
						32'(result.entry_count));
					check_field("top_address", want.top_address, result.top_address);
					check_field("top_bytes", want.top_bytes, result.top_bytes);
				end
			end
			if (frame_valid && frame_ready) begin
				expected_results.push_back(account_frame(frame));
				frames_taken <= frames_taken + 1;
			end
		end
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic queue_frame(input logic [15:0] et, input logic [31:0] src,
		input logic [15:0] len);
		frame_item_t f;
		f.ethertype = et;
		f.src_address = src;
		f.frame_length = len;
		pending_frames.push_back(f);
	endtask

	// A quarter short frames up to the minimum size, some maximal, the rest anywhere.
	function automatic logic [15:0] random_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			return 16'($urandom_range(0, 64));
		end else if (pick < 30) begin
			return 16'hFFFF;
		end
		return 16'($urandom_range(0, 16'hFFFF));
	endfunction

	// Random frames: mostly matching the register, new sources at the given rate.
	task automatic random_phase(input int n, input logic [15:0] et, input int pct_new);
		logic [15:0] etype;
		logic [31:0] src;
		int          k;
		for (k = 0; k < n; k++) begin
			etype = ($urandom_range(0, 99) < 20) ? 16'($urandom_range(0, 16'hFFFF)) : et;
			if ($urandom_range(0, 99) < pct_new) begin
				src = $urandom;
				known_sources.push_back(src);
			end else begin
				src = known_sources[$urandom_range(0, known_sources.size() - 1)];
			end
			queue_frame(etype, src, random_length());
		end
	endtask

	task automatic wait_drained();
		while (pending_frames.size() != 0 || expected_results.size() != 0 || frame_valid) begin
			@(negedge clk);
		end
	endtask

	// The register is only written with the block idle.
	task automatic set_ethertype(input logic [15:0] value);
		wait_drained();
		repeat (5) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Stimulus sequence.
	initial begin
		logic [15:0] any_type;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, minimum size rule, ties for top, extreme fields.
		queue_frame(16'h0801, 32'h1234_5678, 16'd100);
		queue_frame(16'h0800, 32'h0000_0000, 16'd0);
		queue_frame(16'h0800, 32'hFFFF_FFFF, 16'd59);
		queue_frame(16'h0800, 32'hFFFF_FFFF, 16'd60);
		queue_frame(16'h0800, 32'h0000_0000, 16'd64);
		queue_frame(16'h0800, 32'hA5A5_A5A5, 16'hFFFF);
		queue_frame(16'h0800, 32'h0000_0000, 16'hFFFF);
		queue_frame(16'h0800, 32'hFFFF_FFFF, 16'd61);
		queue_frame(16'h0000, 32'h0000_0000, 16'hFFFF);
		queue_frame(16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
		queue_frame(16'h0008, 32'hA5A5_A5A5, 16'd200);
		queue_frame(16'h0800, 32'h5A5A_5A5A, 16'd1);
		// Equal totals: a higher index tying the top does not take it.
		queue_frame(16'h0800, 32'hA5A5_A5A5, 16'd128);
		queue_frame(16'h0800, 32'hA5A5_A5A5, 16'd132);
		// A lower index tying the top takes it.
		queue_frame(16'h0800, 32'h0000_0000, 16'd132);
		queue_frame(16'h0800, 32'h8000_0001, 16'hFFFE);
		queue_frame(16'h0800, 32'h5A5A_5A5A, 16'd63);
		queue_frame(16'h86DD, 32'h8000_0001, 16'd1500);
		known_sources.push_back(32'h0000_0000);
		known_sources.push_back(32'hFFFF_FFFF);
		known_sources.push_back(32'hA5A5_A5A5);
		known_sources.push_back(32'h5A5A_5A5A);
		known_sources.push_back(32'h8000_0001);

		// Random traffic over a few sources so the top sender keeps changing.
		random_phase(250, 16'h0800, 0);

		// Register settings at both extremes, a random one, then back to IPv4.
		set_ethertype(16'h0000);
		random_phase(100, 16'h0000, 40);
		set_ethertype(16'hFFFF);
		random_phase(100, 16'hFFFF, 40);
		any_type = 16'($urandom_range(0, 16'hFFFF));
		set_ethertype(any_type);
		random_phase(100, any_type, 40);
		set_ethertype(16'h0800);
		random_phase(100, 16'h0800, 40);

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
